@@ design/prefix_free_digit_trie_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the prefix-free digit trie
// Shared implication forms, sampled on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_FREE_DIGIT_TRIE_DEFINES_SVH
`define PREFIX_FREE_DIGIT_TRIE_DEFINES_SVH

// Same-cycle implication.
`define PFDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFDT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Prefix-free digit trie package
// Sequencer states and fixed constants of the digit trie.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfdt_pkg;

  // Number of children per node (decimal digits).
  localparam int unsigned RADIX = 10;

  // Width of the digit field and the largest digit that is walked.
  localparam int unsigned DIGIT_W = 4;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // Codes of the kind field.
  localparam logic KIND_DIGIT    = 1'b0;
  localparam logic KIND_NEW_LIST = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_NODE,
    ST_DONE
  } pfdt_state_e;

endpackage

@@ design/pfdt_ram.sv @@
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One access per cycle at one address, which can write, read or both, with the read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfdt_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port. The read data holds until the
  // next read, also across writes.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/prefix_free_digit_trie.sv @@
// ----------------------------------------------------------------------------
// Prefix-free digit trie
// Checks that decimal numbers, entered one digit per word, form a prefix code.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o    | kind_i, digit_i, last_digit_i
//   out     | output    | out_valid_o / out_stall_i  | number_ok_o, list_ok_o, table_full_o
//
// A digit word that is not walked goes straight to the done state. One that
// allocates a node from an empty link passes the link state; one that follows
// a link also passes the node state: the child link memory is read, then the
// node memory is read at the child to check its back-pointer and end mark.
// A new list needs no clearing pass: a link counts only if its child lies
// below the fill count and points back at the same slot, so reset and a new
// list each take effect at once. A finished result waits in the output
// register; only a final digit that meets a full, stalled output holds back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prefix_free_digit_trie_defines.svh"

module prefix_free_digit_trie #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [pfdt_pkg::DIGIT_W-1:0] digit_i,
  input  logic                        last_digit_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        number_ok_o,
  output logic                        list_ok_o,
  output logic                        table_full_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = NW + 1;
  localparam int unsigned SLOTS = MAX_NODES * pfdt_pkg::RADIX;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic [CW-1:0] NODE_LIMIT = CW'(MAX_NODES);

  // Sequencer and walk state.
  pfdt_pkg::pfdt_state_e state_q, state_d;
  logic [NW-1:0] walk_node_q, walk_node_d;
  logic [CW-1:0] nodes_used_q, nodes_used_d;
  logic          made_new_q, made_new_d;
  logic          met_end_q, met_end_d;
  logic          all_ok_q, all_ok_d;
  logic          pool_exh_q, pool_exh_d;
  logic          walk_lost_q, walk_lost_d;
  logic          last_q, last_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] cur_slot_q, cur_slot_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic number_ok_q, number_ok_d;
  logic list_ok_q, list_ok_d;
  logic table_full_q, table_full_d;

  // Memory ports.
  logic          link_we, link_re;
  logic [SW-1:0] link_addr;
  logic [NW-1:0] link_wdata, link_rdata;
  logic          node_we, node_re;
  logic [NW-1:0] node_addr;
  logic [SW:0]   node_wdata, node_rdata;

  logic          accept;
  logic          res_load;
  logic          alloc_req;
  logic          link_hit;
  logic          parent_match;
  logic          number_good;
  logic [SW-1:0] slot_calc;

  // Child link per (node, digit) slot.
  pfdt_ram #(
    .DEPTH (SLOTS),
    .WIDTH (NW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .re_i    (link_re),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  // Per node: the slot that allocated it and its end mark.
  pfdt_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (SW + 1)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .re_i    (node_re),
    .addr_i  (node_addr),
    .wdata_i (node_wdata),
    .rdata_o (node_rdata)
  );

  // Slot of the current node for the incoming digit: node * 10 + digit.
  assign slot_calc = SW'({walk_node_q, 3'b000}) + SW'({walk_node_q, 1'b0}) + SW'(digit_i);

  assign in_stall_o   = (state_q != pfdt_pkg::ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign link_hit     = (link_rdata != '0) && ({1'b0, link_rdata} < nodes_used_q);
  assign parent_match = (node_rdata[SW:1] == slot_q);
  assign number_good  = made_new_q && !met_end_q && !walk_lost_q;

  // Next state, walk updates and memory accesses.
  always_comb begin
    state_d      = state_q;
    walk_node_d  = walk_node_q;
    nodes_used_d = nodes_used_q;
    made_new_d   = made_new_q;
    met_end_d    = met_end_q;
    all_ok_d     = all_ok_q;
    pool_exh_d   = pool_exh_q;
    walk_lost_d  = walk_lost_q;
    last_d       = last_q;
    slot_d       = slot_q;
    cur_slot_d   = cur_slot_q;
    number_ok_d  = number_ok_q;
    list_ok_d    = list_ok_q;
    table_full_d = table_full_q;
    res_load     = 1'b0;
    alloc_req    = 1'b0;
    link_we      = 1'b0;
    link_re      = 1'b0;
    link_addr    = slot_q;
    link_wdata   = nodes_used_q[NW-1:0];
    node_we      = 1'b0;
    node_re      = 1'b0;
    node_addr    = link_rdata;
    node_wdata   = {slot_q, 1'b0};

    case (state_q)
      pfdt_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind_i == pfdt_pkg::KIND_NEW_LIST) begin
            // New list: the fill count alone retires every old link.
            nodes_used_d = CW'(1);
            all_ok_d     = 1'b1;
            pool_exh_d   = 1'b0;
            walk_node_d  = '0;
            made_new_d   = 1'b0;
            met_end_d    = 1'b0;
            walk_lost_d  = 1'b0;
          end else begin
            last_d = last_digit_i;
            if (walk_lost_q || (digit_i > pfdt_pkg::DIGIT_MAX)) begin
              state_d = pfdt_pkg::ST_DONE;
            end else begin
              link_re   = 1'b1;
              link_addr = slot_calc;
              slot_d    = slot_calc;
              state_d   = pfdt_pkg::ST_LINK;
            end
          end
        end
      end

      pfdt_pkg::ST_LINK: begin
        // A plausible link is confirmed against the child's back-pointer.
        if (link_hit) begin
          node_re   = 1'b1;
          node_addr = link_rdata;
          state_d   = pfdt_pkg::ST_NODE;
        end else begin
          alloc_req = 1'b1;
          state_d   = pfdt_pkg::ST_DONE;
        end
      end

      pfdt_pkg::ST_NODE: begin
        if (parent_match) begin
          met_end_d   = met_end_q | node_rdata[0];
          walk_node_d = link_rdata;
          cur_slot_d  = slot_q;
        end else begin
          alloc_req = 1'b1;
        end
        state_d = pfdt_pkg::ST_DONE;
      end

      pfdt_pkg::ST_DONE: begin
        if (!last_q) begin
          state_d = pfdt_pkg::ST_IDLE;
        end else if (!(out_valid_q && out_stall_i)) begin
          // Final digit: mark the reached node unless the walk was lost, and publish the result.
          res_load     = 1'b1;
          number_ok_d  = number_good;
          all_ok_d     = all_ok_q && number_good;
          list_ok_d    = all_ok_q && number_good;
          table_full_d = pool_exh_q;
          if (!walk_lost_q) begin
            node_we    = 1'b1;
            node_addr  = walk_node_q;
            node_wdata = {cur_slot_q, 1'b1};
          end
          walk_node_d = '0;
          made_new_d  = 1'b0;
          met_end_d   = 1'b0;
          walk_lost_d = 1'b0;
          state_d     = pfdt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pfdt_pkg::ST_IDLE;
      end
    endcase

    // Node allocation, shared by an empty link and a stale one.
    if (alloc_req) begin
      if (nodes_used_q < NODE_LIMIT) begin
        link_we      = 1'b1;
        link_addr    = slot_q;
        link_wdata   = nodes_used_q[NW-1:0];
        node_we      = 1'b1;
        node_addr    = nodes_used_q[NW-1:0];
        node_wdata   = {slot_q, 1'b0};
        walk_node_d  = nodes_used_q[NW-1:0];
        cur_slot_d   = slot_q;
        made_new_d   = 1'b1;
        nodes_used_d = nodes_used_q + CW'(1);
      end else begin
        pool_exh_d  = 1'b1;
        met_end_d   = 1'b1;
        walk_lost_d = 1'b1;
      end
    end
  end

  // The output register frees when its word is taken.
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfdt_pkg::ST_IDLE;
      walk_node_q  <= '0;
      nodes_used_q <= CW'(1);
      made_new_q   <= 1'b0;
      met_end_q    <= 1'b0;
      all_ok_q     <= 1'b1;
      pool_exh_q   <= 1'b0;
      walk_lost_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_node_q  <= walk_node_d;
      nodes_used_q <= nodes_used_d;
      made_new_q   <= made_new_d;
      met_end_q    <= met_end_d;
      all_ok_q     <= all_ok_d;
      pool_exh_q   <= pool_exh_d;
      walk_lost_q  <= walk_lost_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    slot_q       <= slot_d;
    cur_slot_q   <= cur_slot_d;
    number_ok_q  <= number_ok_d;
    list_ok_q    <= list_ok_d;
    table_full_q <= table_full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign number_ok_o  = number_ok_q;
  assign list_ok_o    = list_ok_q;
  assign table_full_o = table_full_q;

  // Assertions.
  `PFDT_ASSERT_IMP(a_walk_below_fill, 1'b1, ({1'b0, walk_node_q} < nodes_used_q), "walk node beyond allocated nodes")
  `PFDT_ASSERT_NXT(a_alloc_counts, alloc_req && (nodes_used_q < NODE_LIMIT), (nodes_used_q == $past(nodes_used_q) + CW'(1)), "allocation did not advance the fill count")
  `PFDT_ASSERT_IMP(a_lost_means_full, walk_lost_q, pool_exh_q, "walk abandoned without an exhausted pool")
  `PFDT_ASSERT_IMP(a_no_overwrite, res_load, (!out_valid_q || !out_stall_i), "result loaded over a waiting word")
  `PFDT_ASSERT_NXT(a_list_fail_sticks, res_load && !all_ok_q, !list_ok_o, "list flag recovered without a new list")

endmodule
